// ----- hdl/gsm7u_pkg.sv -----
// Shared types, constants and alphabet tables for the GSM 7-bit unpacker.
`default_nettype none

package gsm7u_pkg;

    localparam int unsigned NUM_SLOTS = 3;

    localparam logic [6:0] ESC_SEPTET      = 7'h1B;
    localparam logic [7:0] MAX_SEPTETS_RST = 8'd9;
    localparam logic [2:0] PHASE_START     = 3'd1;
    localparam logic [2:0] PHASE_WRAP      = 3'd7;

    // Unpacker state carried from one octet to the next
    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] prev;
        logic [7:0] count;
        logic       esc;
        logic       first;
    } t_unpack_state;

    localparam t_unpack_state STATE_RST = '{
        phase: PHASE_START,
        prev:  8'h00,
        count: 8'h00,
        esc:   1'b0,
        first: 1'b1
    };

    // Results of one octet, handed to the output buffer
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] chars;
        logic [1:0]                cnt;
        logic                      empty_end;
        logic                      last;
    } t_unpack_res;

    localparam logic [7:0] BASE_LUT [128] = '{
        8'h40, 8'hA3, 8'h24, 8'hA5, 8'hE8, 8'hE9, 8'hF9, 8'hEC,
        8'hF2, 8'hC7, 8'h0A, 8'hD8, 8'hF8, 8'h0D, 8'hC5, 8'hE5,
        8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hC6, 8'hE6, 8'hDF, 8'hC9,
        8'h20, 8'h21, 8'h22, 8'h23, 8'hA4, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'hA1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5A, 8'hC4, 8'hD6, 8'hD1, 8'hDC, 8'hA7,
        8'hBF, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7A, 8'hE4, 8'hF6, 8'hF1, 8'hFC, 8'hE0
    };

    // Extension table: only a few codes are mapped
    function automatic logic [7:0] ext_lut(input logic [6:0] s);
        logic [7:0] c;
        unique case (s)
            7'h0A:   c = 8'h0C;
            7'h14:   c = 8'h5E;
            7'h28:   c = 8'h7B;
            7'h29:   c = 8'h7D;
            7'h2F:   c = 8'h5C;
            7'h3C:   c = 8'h5B;
            7'h3D:   c = 8'h7E;
            7'h3E:   c = 8'h5D;
            7'h40:   c = 8'h7C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gsm7u_unpack.sv -----
// Septet extraction, septet limit, escape handling and translation of one octet.
`default_nettype none

module gsm7u_unpack
    import gsm7u_pkg::*;
(
    input  wire t_unpack_state i_state,
    input  wire logic [7:0]    i_octet,
    input  wire logic          i_last,
    input  wire logic [7:0]    i_max_septets,
    output t_unpack_res        o_res,
    output t_unpack_state      o_next
);

    always_comb begin
        logic [2:0]           c;
        logic [2:0]           nph;
        logic [15:0]          pair;
        logic [6:0]           sept [NUM_SLOTS];
        logic [NUM_SLOTS-1:0] have;
        logic [7:0]           lim;
        logic [7:0]           cnt;
        logic                 esc;
        logic [1:0]           n;
        logic [NUM_SLOTS-1:0][7:0] ch;
        logic                 push;
        logic [7:0]           pch;

        lim  = (i_max_septets == 8'd0) ? 8'd1 : i_max_septets;
        c    = (i_state.phase == 3'd0) ? PHASE_START : i_state.phase;
        pair = {i_octet, i_state.prev};

        have[0] = 1'b1;
        sept[1] = i_octet[6:0];
        if (i_state.first) begin
            sept[0] = i_octet[6:0];
            have[1] = 1'b0;
            nph     = PHASE_START;
        end else begin
            // septet spans the carried high bits of prev and low bits of this octet
            sept[0] = 7'(pair >> (4'd8 - {1'b0, c}));
            have[1] = (c == PHASE_WRAP);
            nph     = (c == PHASE_WRAP) ? PHASE_START : c + 3'd1;
        end
        // leftover high bits of the final octet
        have[2] = i_last;
        sept[2] = 7'(i_octet >> (4'd8 - {1'b0, nph}));

        cnt = i_state.count;
        esc = i_state.esc;
        n   = 2'd0;
        ch  = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            push = 1'b0;
            pch  = 8'h00;
            if (have[k] && (cnt < lim)) begin
                cnt = cnt + 8'd1;
                if (esc) begin
                    esc  = 1'b0;
                    push = 1'b1;
                    pch  = ext_lut(sept[k]);
                end else if (sept[k] == ESC_SEPTET) begin
                    esc = 1'b1;
                end else begin
                    push = 1'b1;
                    pch  = BASE_LUT[sept[k]];
                end
            end
            if (push && (n != 2'd3)) begin
                ch[n] = pch;
                n     = n + 2'd1;
            end
        end

        // escape left dangling at message end gives a zero byte
        if (i_last && esc && (n != 2'd3)) begin
            ch[n] = 8'h00;
            n     = n + 2'd1;
        end

        o_res.empty_end = i_last && (n == 2'd0);
        o_res.cnt       = o_res.empty_end ? 2'd1 : n;
        o_res.chars     = ch;
        o_res.last      = i_last;

        if (i_last) begin
            o_next = STATE_RST;
        end else begin
            o_next.phase = nph;
            o_next.prev  = i_octet;
            o_next.count = cnt;
            o_next.esc   = esc;
            o_next.first = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gsm7_septet_unpack_latin1.sv -----
// Top level of the GSM 7-bit septet unpacker with Latin-1 translation.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | i_valid / o_ready          | i_packed_octet, i_last_octet
//  output   | o_valid / i_ready          | o_latin1_char, o_char_valid,
//           |                            | o_end_of_message
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (max_septets)
//
// An octet is registered on entry, unpacked combinationally and loaded into a
// three-entry result buffer, and the buffer drains one result per cycle through the
// single output port while the output is not stalled. The next octet is unpacked in
// the cycle the buffer hands out its last result.
// Reset is synchronous and clears the unpacker state and sets max_septets to 9.
// A stall on the output holds the buffer and, once the input register is full, input.
`default_nettype none

module gsm7_septet_unpack_latin1
    import gsm7u_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_packed_octet,
    input  wire logic       i_last_octet,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_latin1_char,
    output logic            o_char_valid,
    output logic            o_end_of_message,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0]    r_max_septets;
    logic          r_in_valid;
    logic [7:0]    r_octet;
    logic          r_last;
    t_unpack_state r_state;
    t_unpack_res   r_buf;
    logic [1:0]    r_idx;

    t_unpack_res   n_res;
    t_unpack_state n_state;
    logic          buf_done;
    logic          buf_free;
    logic          advance;
    logic          idx_last;

    gsm7u_unpack u_unpack (
        .i_state       (r_state),
        .i_octet       (r_octet),
        .i_last        (r_last),
        .i_max_septets (r_max_septets),
        .o_res         (n_res),
        .o_next        (n_state)
    );

    assign idx_last = (r_idx == r_buf.cnt - 2'd1);
    assign buf_done = o_valid && i_ready && idx_last;
    assign buf_free = (r_buf.cnt == 2'd0) || buf_done;
    assign advance  = r_in_valid && buf_free;

    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_valid          = (r_buf.cnt != 2'd0);
    assign o_latin1_char    = r_buf.chars[r_idx];
    assign o_char_valid     = !r_buf.empty_end;
    assign o_end_of_message = r_buf.last && idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_septets <= MAX_SEPTETS_RST;
            r_in_valid    <= 1'b0;
            r_state       <= STATE_RST;
            r_buf.cnt     <= 2'd0;
            r_idx         <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_septets <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                // load all results of this octet at once
                r_state <= n_state;
                r_buf   <= n_res;
                r_idx   <= 2'd0;
            end else if (buf_done) begin
                r_buf.cnt <= 2'd0;
                r_idx     <= 2'd0;
            end else if (o_valid && i_ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_octet <= i_packed_octet;
            r_last  <= i_last_octet;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gsm7u_checker.sv -----
// Port-level assertions for the unpacker and their bind to the top level.
`default_nettype none

module gsm7u_port_assert (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_latin1_char,
    input wire logic       o_char_valid,
    input wire logic       o_end_of_message
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_latin1_char)
            && $stable(o_char_valid) && $stable(o_end_of_message))
        else $error("stalled result beat changed");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_end_of_message)
        else $error("empty result without end of message");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_latin1_char == 8'h00)
        else $error("empty result carries a character");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending or input blocked after reset");

endmodule

bind gsm7_septet_unpack_latin1 gsm7u_port_assert u_gsm7u_port_assert (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_latin1_char    (o_latin1_char),
    .o_char_valid     (o_char_valid),
    .o_end_of_message (o_end_of_message)
);

`default_nettype wire
